/* hw/rtl/crccc_pkg.sv */
// crccc_pkg: types, constants and the single-bit crc step for the crc codeword checker
// no dependencies; imported by every module under hw/rtl
package crccc_pkg;

   localparam int MAX_GEN_BITS = 16;
   localparam int COUNT_BITS   = 24;
   localparam int REM_BITS     = MAX_GEN_BITS - 1;
   localparam int DEG_BITS     = $clog2(MAX_GEN_BITS);
   localparam int LEN_BITS     = 5;
   localparam int POS_BITS     = 5;
   localparam int DATA_SMALL   = 4;
   localparam int DATA_LARGE   = 8;
   localparam int MIN_GEN_LEN  = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

   typedef enum logic [1:0] {
      CSR_GEN_POLY   = 2'd0,
      CSR_GEN_LENGTH = 2'd1,
      CSR_DATA_MODE  = 2'd2,
      CSR_PADDING    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MAX_GEN_BITS-1:0] generator_poly;
      logic [LEN_BITS-1:0]     generator_length;
      logic                    dataword_mode;
      logic [2:0]              padding_bits;
   } cfg_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       stream_start;
   } req_type;

   typedef struct packed {
      logic                  codeword_error;
      logic [REM_BITS-1:0]   remainder;
      logic                  byte_valid;
      logic [7:0]            decoded_byte;
      logic [COUNT_BITS-1:0] codeword_count;
      logic [COUNT_BITS-1:0] error_count;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic [REM_BITS-1:0]   partial_remainder;
      logic [7:0]            dataword_bits;
      logic [POS_BITS-1:0]   bit_position;
      logic [3:0]            high_nibble;
      logic                  nibble_held;
      logic [COUNT_BITS-1:0] checked_total;
      logic [COUNT_BITS-1:0] failed_total;
   } stream_state_type;

   typedef struct packed {
      logic [DEG_BITS-1:0]   deg;
      logic [REM_BITS-1:0]   rmask;
      logic [MAX_GEN_BITS-1:0] gfull;
      logic                  mode;
      logic [POS_BITS-1:0]   dsize;
      logic [POS_BITS-1:0]   csize;
   } gen_type;

   typedef struct packed {
      stream_state_type st;
      logic             done;
      rsp_type          res;
   } step_out_type;

   typedef struct packed {
      logic       load;
      logic [1:0] count;
   } buf_load_type;

   function automatic gen_type gen_derive(cfg_type c);
      gen_type             g;
      logic [LEN_BITS-1:0] len;
      len = c.generator_length;
      if (len < LEN_BITS'(MIN_GEN_LEN)) len = LEN_BITS'(MIN_GEN_LEN);
      if (len > LEN_BITS'(MAX_GEN_BITS)) len = LEN_BITS'(MAX_GEN_BITS);
      g.deg   = DEG_BITS'(len - LEN_BITS'(1));
      g.rmask = REM_BITS'((MAX_GEN_BITS'(1) << g.deg) - MAX_GEN_BITS'(1));
      g.gfull = {1'b0, c.generator_poly[REM_BITS-1:0] & g.rmask}
                | (MAX_GEN_BITS'(1) << g.deg);
      g.mode  = c.dataword_mode;
      g.dsize = c.dataword_mode ? POS_BITS'(DATA_LARGE) : POS_BITS'(DATA_SMALL);
      g.csize = g.dsize + POS_BITS'(g.deg);
      return g;
   endfunction

   function automatic step_out_type crc_bit_step(stream_state_type s, logic b, gen_type g);
      step_out_type            o;
      logic [MAX_GEN_BITS-1:0] t;
      logic [REM_BITS-1:0]     rem;
      o    = '0;
      o.st = s;
      t    = {s.partial_remainder, b} & {g.rmask, 1'b1};
      if (t[g.deg]) t = t ^ g.gfull;
      o.st.partial_remainder = t[REM_BITS-1:0];
      if (s.bit_position < g.dsize) o.st.dataword_bits = {s.dataword_bits[6:0], b};
      o.st.bit_position = s.bit_position + POS_BITS'(1);
      if (o.st.bit_position >= g.csize) begin
         rem    = o.st.partial_remainder & g.rmask;
         o.done = 1'b1;
         if (s.checked_total != COUNT_LIMIT)
            o.st.checked_total = s.checked_total + COUNT_BITS'(1);
         if ((rem != '0) && (s.failed_total != COUNT_LIMIT))
            o.st.failed_total = s.failed_total + COUNT_BITS'(1);
         o.res.codeword_error = (rem != '0);
         o.res.remainder      = rem;
         o.res.codeword_count = o.st.checked_total;
         o.res.error_count    = o.st.failed_total;
         if (g.mode) begin
            o.res.byte_valid   = 1'b1;
            o.res.decoded_byte = o.st.dataword_bits;
         end else if (s.nibble_held) begin
            o.res.byte_valid   = 1'b1;
            o.res.decoded_byte = {s.high_nibble, o.st.dataword_bits[3:0]};
            o.st.nibble_held   = 1'b0;
            o.st.high_nibble   = '0;
         end else begin
            o.st.high_nibble = o.st.dataword_bits[3:0];
            o.st.nibble_held = 1'b1;
         end
         o.st.partial_remainder = '0;
         o.st.dataword_bits     = '0;
         o.st.bit_position      = '0;
      end
      return o;
   endfunction

endpackage

/* hw/rtl/crccc_csr.sv */
// crccc_csr: configuration registers of the crc codeword checker
// depends on crccc_pkg
module crccc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_data,
   output crccc_pkg::cfg_type            cfg
);
   import crccc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator_poly   <= MAX_GEN_BITS'(11);
         cfg_ff.generator_length <= LEN_BITS'(4);
         cfg_ff.dataword_mode    <= 1'b0;
         cfg_ff.padding_bits     <= 3'd0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_GEN_POLY:   cfg_ff.generator_poly   <= csr_data[MAX_GEN_BITS-1:0];
            CSR_GEN_LENGTH: cfg_ff.generator_length <= csr_data[LEN_BITS-1:0];
            CSR_DATA_MODE:  cfg_ff.dataword_mode    <= csr_data[0];
            CSR_PADDING:    cfg_ff.padding_bits     <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

endmodule

/* hw/rtl/crccc_in_stage.sv */
// crccc_in_stage: input register holding one stream byte transaction
// depends on crccc_pkg
module crccc_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crccc_pkg::req_type req_data,
   input  logic               advance,
   output logic               stage_valid,
   output crccc_pkg::req_type stage_data
);
   import crccc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready   = !valid_ff || advance;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) valid_in = 1'b0;
      if (req_valid && req_ready) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

/* hw/rtl/crccc_engine.sv */
// crccc_engine: eight unrolled crc bit steps over one byte plus the stream state registers
// depends on crccc_pkg
module crccc_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      commit,
   input  crccc_pkg::req_type        stage_data,
   input  crccc_pkg::cfg_type        cfg,
   output crccc_pkg::rsp_type [1:0]  results,
   output logic [1:0]                res_count
);
   import crccc_pkg::*;

   stream_state_type state_ff;
   stream_state_type state_in;
   gen_type          gen;
   step_out_type     so;
   rsp_type [1:0]    res;
   logic [1:0]       n;

   assign gen       = gen_derive(cfg);
   assign results   = res;
   assign res_count = n;

   always_comb begin
      state_in = stage_data.stream_start ? '0 : state_ff;
      res      = '0;
      n        = 2'd0;
      so       = '0;
      for (int i = 0; i < 8; i++) begin
         if (!(stage_data.stream_start && (3'(i) < cfg.padding_bits))) begin
            so       = crc_bit_step(state_in, stage_data.stream_byte[3'(7 - i)], gen);
            state_in = so.st;
            if (so.done) begin
               if (n == 2'd0) begin
                  res[0] = so.res;
               end else if (n == 2'd1) begin
                  res[1] = so.res;
               end
               if (n != 2'd2) n = n + 2'd1;
            end
         end
      end
      if (n == 2'd1) begin
         res[0].last_result = 1'b1;
      end else if (n == 2'd2) begin
         res[1].last_result = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/crccc_rsp_buf.sv */
// crccc_rsp_buf: two-entry result register, drains one result per cycle while rsp_ready is high
// depends on crccc_pkg
module crccc_rsp_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  crccc_pkg::buf_load_type  load,
   input  crccc_pkg::rsp_type [1:0] results,
   output logic                     buf_free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output crccc_pkg::rsp_type       rsp_data
);
   import crccc_pkg::*;

   rsp_type    res_ff [2];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       head_ff;
   logic       head_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = res_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign buf_free  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      if (pop) begin
         cnt_in  = cnt_ff - 2'd1;
         head_in = 1'b1;
      end
      if (load.load) begin
         cnt_in  = load.count;
         head_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         head_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.load) begin
         res_ff[0] <= results[0];
         res_ff[1] <= results[1];
      end
   end

endmodule

/* hw/rtl/crc_codeword_checker.sv */
// crc_codeword_checker: top level, checks packed crc codewords in a byte stream
// depends on crccc_pkg, crccc_csr, crccc_in_stage, crccc_engine, crccc_rsp_buf
//
//   channel  direction  payload                 transaction
//   req_     in         crccc_pkg::req_type     one stream byte, optional start mark
//   rsp_     out        crccc_pkg::rsp_type     one checked codeword
//   csr_     in         index 2 bits, data 16   one register write
//
// a byte is held in the input register, then its results (zero, one or two)
// load the result register together; one result leaves per cycle while rsp_ready is high
// throughput is one byte per cycle while rsp_ready is high and each byte makes at most
// one result; a byte making two results occupies the result register until both leave
// synchronous reset clears control state and restores register defaults
// a stall on rsp_ready holds the result register and then the input register
module crc_codeword_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  crccc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output crccc_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import crccc_pkg::*;

   cfg_type       cfg;
   req_type       stage_data;
   logic          stage_valid;
   logic          stage_advance;
   logic          buf_free;
   rsp_type [1:0] results;
   logic [1:0]    res_count;
   buf_load_type  load;

   assign stage_advance = stage_valid && buf_free;
   assign load.load     = stage_advance;
   assign load.count    = res_count;

   crccc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crccc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (stage_advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   crccc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .commit     (stage_advance),
      .stage_data (stage_data),
      .cfg        (cfg),
      .results    (results),
      .res_count  (res_count)
   );

   crccc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .results   (results),
      .buf_free  (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (stage_advance && (res_count != 2'd0)) |=> rsp_valid)
      else $error("results loaded but nothing offered");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.codeword_count != '0))
      else $error("result with zero codeword count");

   a_err_le_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.error_count <= rsp_data.codeword_count))
      else $error("error count above codeword count");

   a_err_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.codeword_error == (rsp_data.remainder != '0)))
      else $error("error flag disagrees with remainder");

endmodule
